>>> rtl/utf8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_pkg: shared types and constants of the UTF-8 decoder
// Byte classes, automaton states and the decode step's result.
// ----------------------------------------------------------------------------
package utf8_pkg;

  localparam int unsigned CpWidth  = 21;
  localparam int unsigned ClsWidth = 4;

  localparam logic [CpWidth-1:0] ErrChar = 21'h00003F;

  typedef enum logic [ClsWidth-1:0] {
    CLS_ASCII   = 4'd0,
    CLS_CONT_8X = 4'd1,
    CLS_LEAD2   = 4'd2,
    CLS_LEAD3   = 4'd3,
    CLS_LEAD_ED = 4'd4,
    CLS_LEAD_F4 = 4'd5,
    CLS_LEAD4   = 4'd6,
    CLS_CONT_AX = 4'd7,
    CLS_INVALID = 4'd8,
    CLS_CONT_9X = 4'd9,
    CLS_LEAD_E0 = 4'd10,
    CLS_LEAD_F0 = 4'd11
  } byte_cls_e;

  typedef enum logic [8:0] {
    ST_ACCEPT = 9'b000000001,
    ST_REJECT = 9'b000000010,
    ST_W2     = 9'b000000100,
    ST_W3     = 9'b000001000,
    ST_W4     = 9'b000010000,
    ST_W5     = 9'b000100000,
    ST_W6     = 9'b001000000,
    ST_W7     = 9'b010000000,
    ST_W8     = 9'b100000000
  } dfa_state_e;

  typedef struct packed {
    dfa_state_e         state;
    logic [CpWidth-1:0] accum;
    logic               emit;
    logic               error;
  } step_res_t;

endpackage

>>> rtl/utf8_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_in_if: byte request channel
// One raw byte per request, with a restart flag for the start of a string.
// ----------------------------------------------------------------------------
interface utf8_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, output data_byte, output restart, input ready);
  modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

>>> rtl/utf8_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_out_if: code point request channel
// One decoded code point, or an error marker, per request.
// ----------------------------------------------------------------------------
interface utf8_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] codepoint;
  logic        error;

  modport source (output valid, output codepoint, output error, input ready);
  modport sink   (input valid, input codepoint, input error, output ready);
endinterface

>>> rtl/utf8_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_step: one decode step
// Byte classification, state transition and accumulator update for one byte.
// ----------------------------------------------------------------------------
module utf8_step
  import utf8_pkg::*;
(
  input  dfa_state_e         state_i,
  input  logic [CpWidth-1:0] accum_i,
  input  logic [7:0]         data_byte_i,
  input  logic               restart_i,
  output step_res_t          res_o
);

  function automatic byte_cls_e byte_class(input logic [7:0] b);
    byte_cls_e c;
    priority if (b <= 8'h7F) c = CLS_ASCII;
    else if (b <= 8'h8F)     c = CLS_CONT_8X;
    else if (b <= 8'h9F)     c = CLS_CONT_9X;
    else if (b <= 8'hBF)     c = CLS_CONT_AX;
    else if (b <= 8'hC1)     c = CLS_INVALID;
    else if (b <= 8'hDF)     c = CLS_LEAD2;
    else if (b == 8'hE0)     c = CLS_LEAD_E0;
    else if (b == 8'hED)     c = CLS_LEAD_ED;
    else if (b <= 8'hEF)     c = CLS_LEAD3;
    else if (b == 8'hF0)     c = CLS_LEAD_F0;
    else if (b <= 8'hF3)     c = CLS_LEAD4;
    else if (b == 8'hF4)     c = CLS_LEAD_F4;
    else                     c = CLS_INVALID;
    return c;
  endfunction

  function automatic dfa_state_e next_state(input dfa_state_e s,
                                            input byte_cls_e c);
    dfa_state_e n;
    n = ST_REJECT;
    unique case (s)
      ST_ACCEPT: begin
        unique case (c)
          CLS_ASCII:   n = ST_ACCEPT;
          CLS_LEAD2:   n = ST_W2;
          CLS_LEAD3:   n = ST_W3;
          CLS_LEAD_ED: n = ST_W5;
          CLS_LEAD_F4: n = ST_W8;
          CLS_LEAD4:   n = ST_W7;
          CLS_LEAD_E0: n = ST_W4;
          CLS_LEAD_F0: n = ST_W6;
          default:     n = ST_REJECT;
        endcase
      end
      ST_W2: if (c == CLS_CONT_8X || c == CLS_CONT_AX || c == CLS_CONT_9X) n = ST_ACCEPT;
      ST_W3: if (c == CLS_CONT_8X || c == CLS_CONT_AX || c == CLS_CONT_9X) n = ST_W2;
      ST_W4: if (c == CLS_CONT_AX) n = ST_W2;
      ST_W5: if (c == CLS_CONT_8X || c == CLS_CONT_9X) n = ST_W2;
      ST_W6: if (c == CLS_CONT_AX || c == CLS_CONT_9X) n = ST_W3;
      ST_W7: if (c == CLS_CONT_8X || c == CLS_CONT_AX || c == CLS_CONT_9X) n = ST_W3;
      ST_W8: if (c == CLS_CONT_8X) n = ST_W3;
      default: n = ST_REJECT;
    endcase
    return n;
  endfunction

  dfa_state_e cur_state;
  byte_cls_e  cls;
  logic [7:0] lead_mask;
  dfa_state_e ns;

  assign cur_state = restart_i ? ST_ACCEPT : state_i;
  assign cls       = byte_class(data_byte_i);
  assign lead_mask = 8'hFF >> cls;
  assign ns        = next_state(cur_state, cls);

  always_comb begin
    res_o.state = cur_state;
    res_o.accum = accum_i;
    res_o.emit  = 1'b0;
    res_o.error = 1'b0;
    if (cur_state != ST_REJECT) begin
      if (cur_state == ST_ACCEPT) begin
        res_o.accum = {{(CpWidth-8){1'b0}}, data_byte_i & lead_mask};
      end else begin
        res_o.accum = {accum_i[CpWidth-7:0], data_byte_i[5:0]};
      end
      res_o.state = ns;
      res_o.emit  = (ns == ST_ACCEPT) || (ns == ST_REJECT);
      res_o.error = (ns == ST_REJECT);
    end
  end

endmodule

>>> rtl/utf8_dfa_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dfa_decoder: validating UTF-8 to UTF-32 decoder
// Table-driven automaton; emits a code point per completed sequence and one
// error marker (0x3F) on entering reject, silent until the next restart.
// ----------------------------------------------------------------------------
// channel  dir  payload                          request
// in_i     in   data_byte[7:0], restart          one byte
// out_o    out  codepoint[20:0], error           one code point or error
//
// One byte per cycle sustained while out_o is ready. Each byte waits in the
// input register; its result, if any, then goes to the output register.
// Decode state lives next to the output register and updates only when
// the output register is free or being drained, so a stall on out_o holds
// at most one byte in the input register before in_i.ready drops.
// Reset puts the automaton in accept and empties both registers.
// ----------------------------------------------------------------------------
module utf8_dfa_decoder
  import utf8_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  utf8_in_if.sink    in_i,
  utf8_out_if.source out_o
);

  logic               s1_valid_q;
  logic [7:0]         s1_byte_q;
  logic               s1_restart_q;
  dfa_state_e         state_q;
  logic [CpWidth-1:0] accum_q;
  logic               out_valid_q;
  logic [CpWidth-1:0] out_cp_q;
  logic               out_err_q;

  logic      advance;
  logic      in_take;
  step_res_t step;

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_take    = in_i.valid && in_i.ready;

  utf8_step u_step (
    .state_i     (state_q),
    .accum_i     (accum_q),
    .data_byte_i (s1_byte_q),
    .restart_i   (s1_restart_q),
    .res_o       (step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= ST_ACCEPT;
      accum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        state_q     <= step.state;
        accum_q     <= step.accum;
        out_valid_q <= step.emit;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q    <= in_i.data_byte;
      s1_restart_q <= in_i.restart;
    end
    if (advance && step.emit) begin
      out_cp_q  <= step.error ? ErrChar : step.accum;
      out_err_q <= step.error;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.codepoint = out_cp_q;
  assign out_o.error     = out_err_q;

endmodule

>>> tb/utf8_dfa_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dfa_decoder_checker: code point predictor and result checker
// Watches both channels, decodes every accepted byte with its own automaton
// and compares each returned code point against the oldest prediction.
// ----------------------------------------------------------------------------
module utf8_dfa_decoder_checker
  import utf8_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  utf8_in_if          in_i,
  utf8_out_if         out_i,
  output int unsigned fail_cnt_o,
  output int unsigned pending_o
);

  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic [CpWidth-1:0] codepoint;
    logic               error;
  } cp_res_t;

  dfa_state_e         dec_state    = ST_ACCEPT;
  logic [CpWidth-1:0] dec_accum    = '0;
  cp_res_t            expected_cps[$];

  function automatic byte_cls_e class_of(input logic [7:0] b);
    if (b < 8'h80)       return CLS_ASCII;
    else if (b < 8'h90)  return CLS_CONT_8X;
    else if (b < 8'hA0)  return CLS_CONT_9X;
    else if (b < 8'hC0)  return CLS_CONT_AX;
    else if (b < 8'hC2)  return CLS_INVALID;
    else if (b < 8'hE0)  return CLS_LEAD2;
    else if (b == 8'hE0) return CLS_LEAD_E0;
    else if (b == 8'hED) return CLS_LEAD_ED;
    else if (b < 8'hF0)  return CLS_LEAD3;
    else if (b == 8'hF0) return CLS_LEAD_F0;
    else if (b < 8'hF4)  return CLS_LEAD4;
    else if (b == 8'hF4) return CLS_LEAD_F4;
    else                 return CLS_INVALID;
  endfunction

  function automatic dfa_state_e next_state_of(input dfa_state_e st, input byte_cls_e cls);
    dfa_state_e nxt;
    nxt = ST_REJECT;
    case (st)
      ST_ACCEPT: begin
        case (cls)
          CLS_ASCII:   nxt = ST_ACCEPT;
          CLS_LEAD2:   nxt = ST_W2;
          CLS_LEAD3:   nxt = ST_W3;
          CLS_LEAD_ED: nxt = ST_W5;
          CLS_LEAD_F4: nxt = ST_W8;
          CLS_LEAD4:   nxt = ST_W7;
          CLS_LEAD_E0: nxt = ST_W4;
          CLS_LEAD_F0: nxt = ST_W6;
          default:     nxt = ST_REJECT;
        endcase
      end
      ST_W2: if (cls inside {CLS_CONT_8X, CLS_CONT_9X, CLS_CONT_AX}) nxt = ST_ACCEPT;
      ST_W3: if (cls inside {CLS_CONT_8X, CLS_CONT_9X, CLS_CONT_AX}) nxt = ST_W2;
      ST_W4: if (cls == CLS_CONT_AX) nxt = ST_W2;
      ST_W5: if (cls inside {CLS_CONT_8X, CLS_CONT_9X}) nxt = ST_W2;
      ST_W6: if (cls inside {CLS_CONT_9X, CLS_CONT_AX}) nxt = ST_W3;
      ST_W7: if (cls inside {CLS_CONT_8X, CLS_CONT_9X, CLS_CONT_AX}) nxt = ST_W3;
      ST_W8: if (cls == CLS_CONT_8X) nxt = ST_W3;
      default: nxt = ST_REJECT;
    endcase
    return nxt;
  endfunction

  task automatic note_failure(input string what, input cp_res_t want, input cp_res_t got);
    if (fail_cnt_o < MaxReports)
      $display("%0t: %s: expected cp=%06h err=%b, got cp=%06h err=%b",
               $time, what, want.codepoint, want.error, got.codepoint, got.error);
    fail_cnt_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cp_res_t   want;
    cp_res_t   got;
    byte_cls_e cls;
    if (!rst_ni) begin
      dec_state = ST_ACCEPT;
      dec_accum = '0;
      expected_cps.delete();
      pending_o  = 0;
      fail_cnt_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got = '{codepoint: out_i.codepoint, error: out_i.error};
        if (expected_cps.size() == 0) begin
          note_failure("unexpected request", '0, got);
        end else begin
          want = expected_cps.pop_front();
          if (got.codepoint !== want.codepoint || got.error !== want.error)
            note_failure("mismatch", want, got);
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.restart) begin
          dec_state = ST_ACCEPT;
          dec_accum = '0;
        end
        // reject stays silent until the next restart
        if (dec_state != ST_REJECT) begin
          cls = class_of(in_i.data_byte);
          if (dec_state != ST_ACCEPT)
            dec_accum = {dec_accum[CpWidth-7:0], in_i.data_byte[5:0]};
          else
            dec_accum = {{(CpWidth-8){1'b0}}, (8'hFF >> cls) & in_i.data_byte};
          dec_state = next_state_of(dec_state, cls);
          if (dec_state == ST_REJECT)
            expected_cps.push_back('{codepoint: ErrChar, error: 1'b1});
          else if (dec_state == ST_ACCEPT)
            expected_cps.push_back('{codepoint: dec_accum, error: 1'b0});
        end
      end
      pending_o = expected_cps.size();
    end
  end

endmodule

>>> tb/utf8_dfa_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_dfa_decoder_tb: stimulus and verdict for the UTF-8 decoder
// Sends directed boundary and malformed sequences, then random streams of
// mostly well-formed code points with truncations, overlongs, surrogates and
// noise, under bursty input and a stalling output.
// ----------------------------------------------------------------------------
module utf8_dfa_decoder_tb;
  import utf8_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned ItemTarget  = 850;
  localparam int unsigned PauseAt     = 650;
  localparam int unsigned HoldStart   = 400;
  localparam int unsigned HoldLen     = 300;
  localparam int unsigned TailCycles  = 10;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_COIN,
    RX_SPARSE,
    RX_DENSE
  } rx_mode_e;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_cnt;
  int unsigned pending_cps;
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;

  utf8_in_if  byte_if ();
  utf8_out_if cp_if ();

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  utf8_dfa_decoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (cp_if)
  );

  utf8_dfa_decoder_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (byte_if),
    .out_i      (cp_if),
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending_cps)
  );

  task automatic send_byte(input logic [7:0] b, input logic rs);
    if (burst_left == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= b;
    byte_if.restart   <= rs;
    do @(posedge clk_i); while (!byte_if.ready);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // encodes cp in len bytes (lengths longer than needed give overlongs) and sends the first keep
  task automatic send_cp(input logic [20:0] cp, input int unsigned len,
                         input int unsigned keep, input logic rs);
    logic [7:0] seq [4];
    case (len)
      1: seq[0] = cp[7:0];
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) send_byte(seq[i], (i == 0) ? rs : 1'b0);
  endtask

  task automatic drain_cps();
    byte_if.valid <= 1'b0;
    wait (pending_cps == 0);
    @(negedge clk_i);
  endtask

  function automatic logic [20:0] rand_cp(input int unsigned len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hF7FF));
        if (cp >= 21'h0D800) cp = cp + 21'h000800;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  initial begin : stimulus
    logic        force_rs;
    logic        rs;
    logic        paused;
    int unsigned pick;
    int unsigned len;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = 8'h00;
    byte_if.restart   = 1'b0;
    force_rs          = 1'b0;
    paused            = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_byte(8'h00, 1'b1);
    send_byte(8'h7F, 1'b0);
    send_cp(21'h000080, 2, 2, 1'b0);
    send_cp(21'h0007FF, 2, 2, 1'b0);
    send_cp(21'h000800, 3, 3, 1'b0);
    send_cp(21'h00FFFF, 3, 3, 1'b0);
    send_cp(21'h10FFFF, 4, 4, 1'b0);
    send_byte(8'hC0, 1'b0);           // overlong lead, enters reject
    send_byte(8'h41, 1'b0);           // dropped while in reject
    send_cp(21'h00D800, 3, 2, 1'b1);  // surrogate
    send_cp(21'h001000, 3, 2, 1'b1);  // left unfinished
    send_byte(8'hFF, 1'b1);           // restart mid-sequence
    send_cp(21'h110000, 4, 2, 1'b1);  // beyond 0x10FFFF
    send_byte(8'h24, 1'b1);
    drain_cps();

    while (bytes_sent < ItemTarget) begin
      if (!paused && bytes_sent >= PauseAt) begin
        drain_cps();
        paused = 1'b1;
      end
      pick     = $urandom_range(0, 99);
      rs       = force_rs || ($urandom_range(0, 9) == 0);
      force_rs = 1'b0;
      if (pick < 72) begin
        len = $urandom_range(1, 4);
        send_cp(rand_cp(len), len, len, rs);
      end else if (pick < 82) begin
        len = $urandom_range(2, 4);
        send_cp(rand_cp(len), len, $urandom_range(1, len - 1), rs);
        force_rs = 1'($urandom_range(0, 1));
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0: begin
            len = $urandom_range(2, 4);
            send_cp(21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF)),
                    len, len, rs);
          end
          1: send_cp(21'($urandom_range('hD800, 'hDFFF)), 3, 3, rs);
          default: send_cp(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4, rs);
        endcase
        force_rs = 1'b1;
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        force_rs = 1'b1;
      end
    end

    byte_if.valid <= 1'b0;
    wait (pending_cps == 0);
    repeat (TailCycles) @(posedge clk_i);
    if (fail_cnt == 0 && pending_cps == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : receiver
    int unsigned rx_cycle;
    rx_mode_e    rx_mode;
    cp_if.ready = 1'b0;
    rx_cycle    = 0;
    rx_mode     = RX_FREE;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = rx_mode_e'($urandom_range(0, 3));
      // long hold-off so the decoder backs up into its input
      if (rx_cycle >= HoldStart && rx_cycle < HoldStart + HoldLen) begin
        cp_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   cp_if.ready <= 1'b1;
          RX_COIN:   cp_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: cp_if.ready <= ($urandom_range(0, 7) == 0);
          default:   cp_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    #(5_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/utf8_pkg.sv
rtl/utf8_in_if.sv
rtl/utf8_out_if.sv
rtl/utf8_step.sv
rtl/utf8_dfa_decoder.sv
tb/utf8_dfa_decoder_checker.sv
tb/utf8_dfa_decoder_tb.sv
